[design/rsd_pkg.sv]
// ----------------------------------------------------------------------------
// rsd_pkg
// shared types and register codes of the rate switched depuncturer
// ----------------------------------------------------------------------------
package rsd_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BITS   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GROUP_SIZE     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PUNCT_MASK     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_UNPUNCT_MASK   = 3'd4;

    // reset values
    localparam logic [15:0] PATTERN_BITS_RST   = 16'hFFFF;
    localparam logic [4:0]  PATTERN_LENGTH_RST = 5'd2;
    localparam logic [2:0]  GROUP_SIZE_RST     = 3'd1;

    typedef struct packed {
        logic [15:0] pattern_bits;
        logic [4:0]  pattern_length;
        logic [2:0]  group_size;
        logic [15:0] punct_mask;
        logic [15:0] unpunct_mask;
    } cfg_t;

    // one result word offered by the walker
    typedef struct packed {
        logic valid;
        logic filler;
        logic last;
    } emit_t;

endpackage

[design/rsd_cfg_regs.sv]
// ----------------------------------------------------------------------------
// rsd_cfg_regs
// configuration register file, write only
// ----------------------------------------------------------------------------
module rsd_cfg_regs
    import rsd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_PATTERN_BITS:   cfg_next.pattern_bits   = cfg_wdata;
                REG_PATTERN_LENGTH: cfg_next.pattern_length = cfg_wdata[4:0];
                REG_GROUP_SIZE:     cfg_next.group_size     = cfg_wdata[2:0];
                REG_PUNCT_MASK:     cfg_next.punct_mask     = cfg_wdata;
                REG_UNPUNCT_MASK:   cfg_next.unpunct_mask   = cfg_wdata;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pattern_bits   <= PATTERN_BITS_RST;
            cfg_reg.pattern_length <= PATTERN_LENGTH_RST;
            cfg_reg.group_size     <= GROUP_SIZE_RST;
            cfg_reg.punct_mask     <= '0;
            cfg_reg.unpunct_mask   <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[design/rsd_step_unit.sv]
// ----------------------------------------------------------------------------
// rsd_step_unit
// shared wrap-around incrementer for pattern position and the filler or group counter
// ----------------------------------------------------------------------------
module rsd_step_unit #(
    parameter int PATTERN_MAX = 16,
    parameter int GROUP_MAX   = 4
) (
    input  logic [$clog2(PATTERN_MAX)-1:0]                     pos,
    input  logic [$clog2(PATTERN_MAX + 1)-1:0]                 len,
    input  logic [((GROUP_MAX > 1) ? $clog2(GROUP_MAX) : 1)-1:0] cnt,
    input  logic [$clog2(GROUP_MAX + 1)-1:0]                   gs,
    output logic [$clog2(PATTERN_MAX)-1:0]                     pos_next,
    output logic [((GROUP_MAX > 1) ? $clog2(GROUP_MAX) : 1)-1:0] cnt_next,
    output logic                                               cnt_wrap
);

    localparam int PW  = $clog2(PATTERN_MAX);
    localparam int LW  = $clog2(PATTERN_MAX + 1);
    localparam int GCW = (GROUP_MAX > 1) ? $clog2(GROUP_MAX) : 1;
    localparam int GSW = $clog2(GROUP_MAX + 1);

    logic [LW-1:0]  pos_inc;
    logic [GSW-1:0] cnt_inc;

    assign pos_inc  = LW'(pos) + LW'(1);
    assign pos_next = (pos_inc >= len) ? '0 : pos_inc[PW-1:0];

    assign cnt_inc  = GSW'(cnt) + GSW'(1);
    assign cnt_wrap = (cnt_inc >= gs);
    assign cnt_next = cnt_wrap ? '0 : cnt_inc[GCW-1:0];

endmodule

[design/rsd_walker.sv]
// ----------------------------------------------------------------------------
// rsd_walker
// sequencer: rate tracking, mode switch and pattern walk, while not stalled one result a cycle
// ----------------------------------------------------------------------------
module rsd_walker
    import rsd_pkg::*;
#(
    parameter int PATTERN_MAX = 16,
    parameter int GROUP_MAX   = 4,
    parameter int SOFT_WIDTH  = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  cfg_t                         cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [SOFT_WIDTH-1:0] in_soft,
    input  logic [3:0]                   in_rate,
    output emit_t                        emit,
    output logic signed [SOFT_WIDTH-1:0] emit_soft,
    input  logic                         out_free
);

    localparam int PW  = $clog2(PATTERN_MAX);
    localparam int LW  = $clog2(PATTERN_MAX + 1);
    localparam int GCW = (GROUP_MAX > 1) ? $clog2(GROUP_MAX) : 1;
    localparam int GSW = $clog2(GROUP_MAX + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic                         state_reg,  state_next;
    logic signed [SOFT_WIDTH-1:0] soft_reg,   soft_next;
    logic                         active_reg, active_next;
    logic [3:0]                   rate_reg,   rate_next;
    logic                         seen_reg,   seen_next;
    logic [PW-1:0]                pos_reg,    pos_next;
    logic [GCW-1:0]               gc_reg,     gc_next;
    logic [GCW-1:0]               fcnt_reg,   fcnt_next;
    logic [PW-1:0]                steps_reg,  steps_next;

    logic [LW-1:0]       len_eff;
    logic [GSW-1:0]      gs_eff;
    logic [PATTERN_MAX-1:0] keep;
    logic                rate_change;
    logic                act_new;
    logic [PW-1:0]       pos_acc;
    logic [GCW-1:0]      gc_acc;
    logic                fill_cond;
    logic [GCW-1:0]      unit_cnt;
    logic [PW-1:0]       unit_pos;
    logic [GCW-1:0]      unit_cnt_next;
    logic                unit_cnt_wrap;
    logic [PW-1:0]       pos_next_unit;

    // clamp out-of-range pattern lengths and group sizes
    always_comb begin
        if (cfg.pattern_length == 5'd0)
            len_eff = LW'(1);
        else if (cfg.pattern_length > 5'(PATTERN_MAX))
            len_eff = LW'(PATTERN_MAX);
        else
            len_eff = cfg.pattern_length[LW-1:0];
        if (cfg.group_size == 3'd0)
            gs_eff = GSW'(1);
        else if (cfg.group_size > 3'(GROUP_MAX))
            gs_eff = GSW'(GROUP_MAX);
        else
            gs_eff = cfg.group_size[GSW-1:0];
    end

    assign keep = cfg.pattern_bits[PATTERN_MAX-1:0];

    // mode and position as seen by a newly accepted word
    always_comb begin
        rate_change = !seen_reg || (in_rate != rate_reg);
        if (cfg.punct_mask[in_rate])
            act_new = 1'b1;
        else if (cfg.unpunct_mask[in_rate])
            act_new = 1'b0;
        else
            act_new = active_reg;
        pos_acc = rate_change ? '0 : pos_reg;
        gc_acc  = rate_change ? '0 : gc_reg;
        if (act_new) begin
            if (LW'(pos_acc) >= len_eff) pos_acc = '0;
            if (GSW'(gc_acc) >= gs_eff)  gc_acc  = '0;
        end
    end

    assign fill_cond = active_reg && (gc_reg == '0) &&
                       ((LW'(steps_reg) + LW'(1)) < len_eff) && !keep[pos_reg];

    // the step unit serves the filler counter or the group counter
    assign unit_cnt = fill_cond ? fcnt_reg : gc_reg;
    assign unit_pos = pos_reg;

    rsd_step_unit #(
        .PATTERN_MAX (PATTERN_MAX),
        .GROUP_MAX   (GROUP_MAX)
    ) u_step (
        .pos      (unit_pos),
        .len      (len_eff),
        .cnt      (unit_cnt),
        .gs       (gs_eff),
        .pos_next (pos_next_unit),
        .cnt_next (unit_cnt_next),
        .cnt_wrap (unit_cnt_wrap)
    );

    assign in_ready = (state_reg == ST_IDLE);

    assign emit.valid = (state_reg == ST_WALK);
    assign emit.filler = fill_cond;
    assign emit.last   = !fill_cond;
    assign emit_soft   = fill_cond ? '0 : soft_reg;

    always_comb begin
        state_next  = state_reg;
        soft_next   = soft_reg;
        active_next = active_reg;
        rate_next   = rate_reg;
        seen_next   = seen_reg;
        pos_next    = pos_reg;
        gc_next     = gc_reg;
        fcnt_next   = fcnt_reg;
        steps_next  = steps_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    soft_next   = in_soft;
                    rate_next   = in_rate;
                    seen_next   = 1'b1;
                    active_next = act_new;
                    pos_next    = pos_acc;
                    gc_next     = gc_acc;
                    fcnt_next   = '0;
                    steps_next  = '0;
                    state_next  = ST_WALK;
                end
            end
            ST_WALK: begin
                if (out_free) begin
                    if (fill_cond) begin
                        fcnt_next = unit_cnt_next;
                        if (unit_cnt_wrap) begin
                            pos_next   = pos_next_unit;
                            steps_next = steps_reg + PW'(1);
                        end
                    end else begin
                        if (active_reg) begin
                            gc_next = unit_cnt_next;
                            if (unit_cnt_wrap) pos_next = pos_next_unit;
                        end
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            active_reg <= 1'b0;
            rate_reg   <= '0;
            seen_reg   <= 1'b0;
            pos_reg    <= '0;
            gc_reg     <= '0;
            fcnt_reg   <= '0;
            steps_reg  <= '0;
        end else begin
            state_reg  <= state_next;
            active_reg <= active_next;
            rate_reg   <= rate_next;
            seen_reg   <= seen_next;
            pos_reg    <= pos_next;
            gc_reg     <= gc_next;
            fcnt_reg   <= fcnt_next;
            steps_reg  <= steps_next;
        end
    end

    always_ff @(posedge aclk) begin
        soft_reg <= soft_next;
    end

endmodule

[design/rate_switched_depuncturer_core.sv]
// ----------------------------------------------------------------------------
// rate_switched_depuncturer_core
// rate switched depuncturer: inserts zero erasures for dropped pattern groups
// ----------------------------------------------------------------------------
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata: soft_in, tuser: rate_code
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: soft_out, tuser: is_filler,
//                                                tlast: last_of_run
//  cfg       in   cfg_wr_en (no back-pressure)   cfg_index, cfg_wdata
//
//  in punctured mode an input word yields group_size filler words per dropped
//  position and then its own value, emitted by the walker one word a cycle
//  while m_axis does not stall, through the shared position/group step unit
//  s_axis_tready is high only while the walker is idle
//  a stalled m_axis holds the walker; the output register lets the next
//  input word be taken while the last result still waits
//  reset is synchronous, active low; it restores register defaults and mode
// ----------------------------------------------------------------------------
module rate_switched_depuncturer_core
    import rsd_pkg::*;
#(
    parameter int PATTERN_MAX = 16,
    parameter int GROUP_MAX   = 4,
    parameter int SOFT_WIDTH  = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [((SOFT_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,  // soft_in
    input  logic [3:0]             s_axis_tuser,  // rate_code
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [((SOFT_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,  // soft_out
    output logic                   m_axis_tuser,  // is_filler
    output logic                   m_axis_tlast,  // last_of_run
    // configuration writes
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    // tdata padded to whole bytes
    localparam int DATA_W = ((SOFT_WIDTH + 7) / 8) * 8;

    cfg_t                         cfg;
    emit_t                        emit;
    logic signed [SOFT_WIDTH-1:0] emit_soft;
    logic                         out_free;

    // output register
    logic                         m_valid_reg, m_valid_next;
    logic signed [SOFT_WIDTH-1:0] m_soft_reg,  m_soft_next;
    logic                         m_fill_reg,  m_fill_next;
    logic                         m_last_reg,  m_last_next;

    rsd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rsd_walker #(
        .PATTERN_MAX (PATTERN_MAX),
        .GROUP_MAX   (GROUP_MAX),
        .SOFT_WIDTH  (SOFT_WIDTH)
    ) u_walker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_soft   (s_axis_tdata[SOFT_WIDTH-1:0]),
        .in_rate   (s_axis_tuser),
        .emit      (emit),
        .emit_soft (emit_soft),
        .out_free  (out_free)
    );

    // a word can be loaded when the register is empty or being drained
    assign out_free = !m_valid_reg || m_axis_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_soft_next  = m_soft_reg;
        m_fill_next  = m_fill_reg;
        m_last_next  = m_last_reg;
        if (emit.valid && out_free) begin
            m_valid_next = 1'b1;
            m_soft_next  = emit_soft;
            m_fill_next  = emit.filler;
            m_last_next  = emit.last;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        m_soft_reg <= m_soft_next;
        m_fill_reg <= m_fill_next;
        m_last_reg <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = DATA_W'($unsigned(m_soft_reg));
    assign m_axis_tuser  = m_fill_reg;
    assign m_axis_tlast  = m_last_reg;

    // a filler word is an exact zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_soft_reg == '0)
        else $error("filler word with nonzero soft value");

    // the passed value closes the run, a filler never does
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tuser != m_axis_tlast)
        else $error("filler and last flags disagree");

    // an accepted word keeps the walker busy in the following cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again right after accept");

    // the walker goes idle only after handing over the last word of a run
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(s_axis_tready) |-> $past(emit.valid && emit.last && out_free))
        else $error("walker went idle without a closing word");

endmodule
